// ===== src/bqf_pkg.sv =====
package bqf_pkg;

  localparam int ACC_W          = 60;
  localparam int COEF_W         = 32;
  localparam int COEF_FRAC_BITS = 28;
  localparam int YSPLIT         = 32;
  localparam int MUL_W          = 33;
  localparam int PROD_W         = 2 * MUL_W;
  localparam int SUM_W          = PROD_W + YSPLIT + 1;
  localparam int CFG_ADDR_W     = 3;

  localparam logic [CFG_ADDR_W-1:0] REG_B0 = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] REG_B1 = CFG_ADDR_W'(1);
  localparam logic [CFG_ADDR_W-1:0] REG_B2 = CFG_ADDR_W'(2);
  localparam logic [CFG_ADDR_W-1:0] REG_A1 = CFG_ADDR_W'(3);
  localparam logic [CFG_ADDR_W-1:0] REG_A2 = CFG_ADDR_W'(4);

  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [COEF_W-1:0] coef_word_t;
  typedef logic signed [MUL_W-1:0]  mul_op_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  typedef struct packed {
    coef_word_t b0;
    coef_word_t b1;
    coef_word_t b2;
    coef_word_t a1;
    coef_word_t a2;
  } coef_t;

  // clamp a wide signed value into the 60-bit state range
  function automatic acc_t sat_acc(input sum_t v);
    logic in_range;
    in_range = (&v[SUM_W-1:ACC_W-1]) || !(|v[SUM_W-1:ACC_W-1]);
    if (in_range) begin
      sat_acc = v[ACC_W-1:0];
    end else if (v[SUM_W-1]) begin
      sat_acc = {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      sat_acc = {1'b0, {(ACC_W-1){1'b1}}};
    end
  endfunction

  function automatic mul_op_t coef_op(input coef_word_t c);
    coef_op = {{(MUL_W-COEF_W){c[COEF_W-1]}}, c};
  endfunction

endpackage

// ===== src/bqf_coef_regs.sv =====
module bqf_coef_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [bqf_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [bqf_pkg::COEF_W-1:0]       cfg_wdata_i,
  output bqf_pkg::coef_t                   coef_o
);
  import bqf_pkg::*;

  coef_t coef_q, coef_d;

  always_comb begin
    coef_d = coef_q;
    if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_B0:  coef_d.b0 = cfg_wdata_i;
        REG_B1:  coef_d.b1 = cfg_wdata_i;
        REG_B2:  coef_d.b2 = cfg_wdata_i;
        REG_A1:  coef_d.a1 = cfg_wdata_i;
        REG_A2:  coef_d.a2 = cfg_wdata_i;
        default: coef_d = coef_q;
      endcase
    end
  end

  // b0 is the top word of the packed set
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= {COEF_W'(1) << COEF_FRAC_BITS, {(4*COEF_W){1'b0}}};
    end else begin
      coef_q <= coef_d;
    end
  end

  assign coef_o = coef_q;

endmodule

// ===== src/bqf_mul.sv =====
module bqf_mul (
  input  logic              clk_i,
  input  bqf_pkg::mul_op_t  a_i,
  input  bqf_pkg::mul_op_t  b_i,
  output bqf_pkg::prod_t    prod_o
);
  import bqf_pkg::*;

  prod_t prod_q;

  // registered signed product, shared by every multiply of the filter step
  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;

endmodule

// ===== src/biquad_tdf2_filter_core.sv =====
// Biquad IIR filter, transposed direct form II, fixed point.
//
// Input channel (in_valid_i / in_ready_o): one signed sample plus a
// clear_history flag that zeroes both state words before the sample.
// Output channel (out_valid_o / out_ready_i): the filtered sample, rounded
// to nearest and saturated, plus a clipped flag.
// Coefficients b0, b1, b2, a1, a2 (signed Q3.28) are written through
// cfg_we_i / cfg_addr_i / cfg_wdata_i while no sample is in flight.
//
// Sequencing: all five products go through one 33x33 multiplier, one pass per
// cycle (the two feedback products as two partials each), under an 8-step
// sequencer. out_valid_o rises when the sequencer leaves its last step;
// in_ready_o returns at the same edge, so no new sample is taken before the
// last one is finished. A finished result sits in the output register, and
// the next sample is taken while it waits. If the receiver still stalls when
// the following result is ready, the sequencer holds in its last step.
// Reset: b0 = 1.0, other coefficients 0, both state words cleared, no
// result pending.
module biquad_tdf2_filter_core #(
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0]      sample_in_i,
  input  logic                                clear_history_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0]      sample_out_o,
  output logic                                clipped_o,
  input  logic                                cfg_we_i,
  input  logic [bqf_pkg::CFG_ADDR_W-1:0]      cfg_addr_i,
  input  logic [bqf_pkg::COEF_W-1:0]          cfg_wdata_i
);
  import bqf_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_B1   = 4'd1;
  localparam logic [3:0] ST_B2   = 4'd2;
  localparam logic [3:0] ST_A1L  = 4'd3;
  localparam logic [3:0] ST_A1H  = 4'd4;
  localparam logic [3:0] ST_A2L  = 4'd5;
  localparam logic [3:0] ST_A2H  = 4'd6;
  localparam logic [3:0] ST_FB2  = 4'd7;
  localparam logic [3:0] ST_DONE = 4'd8;

  localparam logic signed [ACC_W:0] RND_HALF = (ACC_W+1)'(1) << (COEF_FRAC_BITS - 1);

  coef_t coef;

  logic [3:0] state_q, state_d;
  logic       in_acc;
  logic       out_load;

  logic signed [SAMPLE_WIDTH-1:0] x_q;
  acc_t                            y_q, d1_q, d2_q, fbsat_q;
  logic signed [PROD_W:0]          acc1_q;
  prod_t                           acc2_q, fb_q;

  mul_op_t op_a, op_b;
  prod_t   prod;

  mul_op_t x_op, yl_op, yh_op;
  sum_t    fb_sum, fb_shift, y_sum, acc1_sum, d1_sum, d2_sum;
  acc_t    fb_sat;

  logic signed [ACC_W:0] rnd_sum, rnd_shift;
  logic                  out_in_range;
  logic signed [SAMPLE_WIDTH-1:0] out_sat;

  logic                            out_valid_q;
  logic signed [SAMPLE_WIDTH-1:0]  sample_out_q;
  logic                            clipped_q;

  bqf_coef_regs u_coef (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .coef_o      (coef)
  );

  bqf_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (op_a),
    .b_i    (op_b),
    .prod_o (prod)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  // y is split into an unsigned low word and a signed high word
  assign x_op  = {{(MUL_W-SAMPLE_WIDTH){x_q[SAMPLE_WIDTH-1]}}, x_q};
  assign yl_op = {{(MUL_W-YSPLIT){1'b0}}, y_q[YSPLIT-1:0]};
  assign yh_op = {{(MUL_W-ACC_W+YSPLIT){y_q[ACC_W-1]}}, y_q[ACC_W-1:YSPLIT]};

  always_comb begin
    case (state_q)
      ST_IDLE: begin
        op_a = {{(MUL_W-SAMPLE_WIDTH){sample_in_i[SAMPLE_WIDTH-1]}}, sample_in_i};
        op_b = coef_op(coef.b0);
      end
      ST_B1: begin
        op_a = x_op;
        op_b = coef_op(coef.b1);
      end
      ST_B2: begin
        op_a = x_op;
        op_b = coef_op(coef.b2);
      end
      ST_A1L: begin
        op_a = yl_op;
        op_b = coef_op(coef.a1);
      end
      ST_A1H: begin
        op_a = yh_op;
        op_b = coef_op(coef.a1);
      end
      ST_A2L: begin
        op_a = yl_op;
        op_b = coef_op(coef.a2);
      end
      ST_A2H: begin
        op_a = yh_op;
        op_b = coef_op(coef.a2);
      end
      default: begin
        op_a = x_op;
        op_b = coef_op(coef.b0);
      end
    endcase
  end

  // feedback product: low partial in fb_q, high partial on the multiplier output
  assign fb_sum   = sum_t'(fb_q) + (sum_t'(prod) <<< YSPLIT);
  assign fb_shift = fb_sum >>> COEF_FRAC_BITS;
  assign fb_sat   = sat_acc(fb_shift);

  assign y_sum    = sum_t'(prod) + sum_t'(d1_q);
  assign acc1_sum = sum_t'(prod) + sum_t'(d2_q);
  assign d1_sum   = sum_t'(acc1_q) - sum_t'(fbsat_q);
  assign d2_sum   = sum_t'(acc2_q) - sum_t'(fbsat_q);

  // output: round half up, then clamp to the sample range
  assign rnd_sum      = {y_q[ACC_W-1], y_q} + RND_HALF;
  assign rnd_shift    = rnd_sum >>> COEF_FRAC_BITS;
  assign out_in_range = (&rnd_shift[ACC_W:SAMPLE_WIDTH-1]) ||
                        !(|rnd_shift[ACC_W:SAMPLE_WIDTH-1]);

  always_comb begin
    if (out_in_range) begin
      out_sat = rnd_shift[SAMPLE_WIDTH-1:0];
    end else if (rnd_shift[ACC_W]) begin
      out_sat = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    end else begin
      out_sat = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) state_d = ST_B1;
      end
      ST_B1:   state_d = ST_B2;
      ST_B2:   state_d = ST_A1L;
      ST_A1L:  state_d = ST_A1H;
      ST_A1H:  state_d = ST_A2L;
      ST_A2L:  state_d = ST_A2H;
      ST_A2H:  state_d = ST_FB2;
      ST_FB2:  state_d = ST_DONE;
      ST_DONE: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      d1_q        <= '0;
      d2_q        <= '0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (in_acc && clear_history_i) begin
        d1_q <= '0;
        d2_q <= '0;
      end
      if (state_q == ST_A2H) d1_q <= sat_acc(d1_sum);
      if (state_q == ST_DONE) d2_q <= sat_acc(d2_sum);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) x_q <= sample_in_i;
    case (state_q)
      ST_B1:   y_q     <= sat_acc(y_sum);
      ST_B2:   acc1_q  <= acc1_sum[PROD_W:0];
      ST_A1L:  acc2_q  <= prod;
      ST_A1H:  fb_q    <= prod;
      ST_A2L:  fbsat_q <= fb_sat;
      ST_A2H:  fb_q    <= prod;
      ST_FB2:  fbsat_q <= fb_sat;
      default: fb_q    <= fb_q;
    endcase
    if (out_load) begin
      sample_out_q <= out_sat;
      clipped_q    <= !out_in_range;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = sample_out_q;
  assign clipped_o    = clipped_q;

endmodule

// ===== src/bqf_checker.sv =====
module bqf_checker #(
  parameter int SAMPLE_WIDTH = 24
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [SAMPLE_WIDTH-1:0]        sample_out_o,
  input logic                           clipped_o
);

  logic [1:0] pend_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // transactions taken in but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 2'd0;
    end else begin
      pend_q <= pend_q + 2'(in_acc) - 2'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(sample_out_o) && $stable(clipped_o))
    else $error("output changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o ##1 !in_ready_o ##1 !in_ready_o ##1 !in_ready_o
               ##1 !in_ready_o ##1 !in_ready_o ##1 !in_ready_o ##1 !in_ready_o)
    else $error("input taken while a sample is in flight");

  a_no_extra_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 2'd0)
    else $error("result without a pending input");

  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> pend_q != 2'd2)
    else $error("input taken with two results outstanding");

endmodule

bind biquad_tdf2_filter_core bqf_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_bqf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .sample_out_o (sample_out_o),
  .clipped_o    (clipped_o)
);

// ===== verif/biquad_tdf2_filter_core_test.sv =====
`timescale 1ns / 1ps

module biquad_tdf2_filter_core_test;

  localparam int SAMPLE_W      = 24;
  localparam int FRAC          = bqf_pkg::COEF_FRAC_BITS;
  localparam int STALL_LIMIT   = 2000;
  localparam int ITEMS_PER_SEG = 103;
  localparam int N_DIRECTED    = 23;
  localparam int DRAIN_CYCLES  = 20;

  typedef bqf_pkg::coef_word_t coef_word_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [95:0] wide_t;

  typedef struct packed {
    sample_t sample;
    logic    clipped;
  } filter_result_t;

  typedef struct packed {
    logic [1:0] coef_set;
    sample_t    x;
    logic       clr;
    logic       fixed;
    sample_t    y;
    logic       clip;
  } directed_row_t;

  typedef enum int unsigned {
    COEF_EXTREME,
    COEF_MODERATE,
    COEF_WILD
  } coef_mix_e;

  localparam sample_t    SMAX = 24'h7F_FFFF;
  localparam sample_t    SMIN = 24'h80_0000;
  localparam coef_word_t ONE  = 32'sh1000_0000;
  localparam coef_word_t HALF = 32'sh0800_0000;
  localparam coef_word_t CMAX = 32'sh7FFF_FFFF;
  localparam coef_word_t CMIN = 32'sh8000_0000;

  localparam wide_t STATE_MAX = (96'sd1 <<< (bqf_pkg::ACC_W - 1)) - 96'sd1;
  localparam wide_t STATE_MIN = -STATE_MAX - 96'sd1;

  // coefficient sets for the directed rows; set 0 is the reset state
  localparam bqf_pkg::coef_t DIRECTED_SETS [4] = '{
    '{ONE,  32'sd0, 32'sd0, 32'sd0, 32'sd0},
    '{HALF, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
    '{CMAX, CMAX,   CMAX,   CMIN,   CMIN},
    '{CMIN, CMIN,   CMIN,   CMAX,   CMAX}
  };

  localparam directed_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    // pass-through after reset
    '{2'd0, 24'sd0,      1'b0, 1'b1, 24'sd0,      1'b0},
    '{2'd0, SMAX,        1'b0, 1'b1, SMAX,        1'b0},
    '{2'd0, SMIN,        1'b0, 1'b1, SMIN,        1'b0},
    '{2'd0, 24'sd1,      1'b0, 1'b1, 24'sd1,      1'b0},
    '{2'd0, -24'sd1,     1'b0, 1'b1, -24'sd1,     1'b0},
    '{2'd0, 24'h5A_5A5A, 1'b1, 1'b1, 24'h5A_5A5A, 1'b0},
    // gain 0.5: odd inputs land on exact halves, ties go up
    '{2'd1, 24'sd1,      1'b0, 1'b1, 24'sd1,      1'b0},
    '{2'd1, -24'sd1,     1'b0, 1'b1, 24'sd0,      1'b0},
    '{2'd1, 24'sd3,      1'b0, 1'b1, 24'sd2,      1'b0},
    '{2'd1, -24'sd3,     1'b0, 1'b1, -24'sd1,     1'b0},
    '{2'd1, SMAX,        1'b0, 1'b1, 24'sd4194304, 1'b0},
    '{2'd1, SMIN,        1'b0, 1'b1, -24'sd4194304, 1'b0},
    // runaway feedback drives the accumulators into saturation
    '{2'd2, SMAX,        1'b1, 1'b1, SMAX,        1'b1},
    '{2'd2, SMAX,        1'b0, 1'b0, 24'sd0,      1'b0},
    '{2'd2, SMAX,        1'b0, 1'b0, 24'sd0,      1'b0},
    '{2'd2, SMAX,        1'b0, 1'b0, 24'sd0,      1'b0},
    '{2'd2, SMIN,        1'b0, 1'b0, 24'sd0,      1'b0},
    '{2'd2, 24'sd0,      1'b0, 1'b0, 24'sd0,      1'b0},
    '{2'd2, 24'sd0,      1'b1, 1'b1, 24'sd0,      1'b0},
    '{2'd3, SMAX,        1'b1, 1'b1, SMIN,        1'b1},
    '{2'd3, SMIN,        1'b0, 1'b0, 24'sd0,      1'b0},
    '{2'd3, SMAX,        1'b0, 1'b0, 24'sd0,      1'b0},
    '{2'd3, 24'sd1,      1'b0, 1'b0, 24'sd0,      1'b0}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  sample_t sample_in_i = '0;
  logic clear_history_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  sample_t sample_out_o;
  logic clipped_o;
  logic cfg_we_i = 1'b0;
  logic [bqf_pkg::CFG_ADDR_W-1:0] cfg_addr_i = '0;
  logic [bqf_pkg::COEF_W-1:0] cfg_wdata_i = '0;

  bqf_pkg::coef_t coef_shadow;
  wide_t tap1_state;
  wide_t tap2_state;
  filter_result_t pending_results [$];
  int mismatch_count = 0;
  int stall_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  biquad_tdf2_filter_core #(
    .SAMPLE_WIDTH(SAMPLE_W)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .sample_in_i    (sample_in_i),
    .clear_history_i(clear_history_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .sample_out_o   (sample_out_o),
    .clipped_o      (clipped_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic wide_t clamp_state(input wide_t v);
    if (v > STATE_MAX) return STATE_MAX;
    if (v < STATE_MIN) return STATE_MIN;
    return v;
  endfunction

  // y * c floored to the state's fraction bits, then clamped
  function automatic wide_t fb_product(input wide_t y, input coef_word_t c);
    wide_t cw;
    cw = $signed(c);
    return clamp_state((y * cw) >>> FRAC);
  endfunction

  function automatic filter_result_t run_filter(input sample_t x, input logic clr);
    wide_t xw, yw, rw, next1, lim_hi, lim_lo;
    wide_t b0w, b1w, b2w;
    filter_result_t res;
    xw = x;
    b0w = $signed(coef_shadow.b0);
    b1w = $signed(coef_shadow.b1);
    b2w = $signed(coef_shadow.b2);
    lim_hi = SMAX;
    lim_lo = SMIN;
    if (clr) begin
      tap1_state = '0;
      tap2_state = '0;
    end
    yw = clamp_state(b0w * xw + tap1_state);
    next1 = clamp_state(b1w * xw - fb_product(yw, coef_shadow.a1) + tap2_state);
    tap2_state = clamp_state(b2w * xw - fb_product(yw, coef_shadow.a2));
    tap1_state = next1;
    rw = (yw + (96'sd1 <<< (FRAC - 1))) >>> FRAC;
    res.clipped = 1'b1;
    if (rw > lim_hi) begin
      res.sample = SMAX;
    end else if (rw < lim_lo) begin
      res.sample = SMIN;
    end else begin
      res.sample = rw[SAMPLE_W-1:0];
      res.clipped = 1'b0;
    end
    return res;
  endfunction

  function automatic coef_word_t pick_coef(input coef_mix_e mix, input int unsigned span);
    case (mix)
      COEF_EXTREME: begin
        case ($urandom_range(4))
          0: return CMIN;
          1: return CMAX;
          2: return '0;
          3: return ONE;
          default: return -ONE;
        endcase
      end
      COEF_MODERATE: return coef_word_t'(int'($urandom_range(0, 2 << span)) - (1 << span));
      default: return coef_word_t'($urandom);
    endcase
  endfunction

  function automatic bqf_pkg::coef_t random_coefs(input coef_mix_e mix);
    bqf_pkg::coef_t c;
    c.b0 = pick_coef(mix, 28);
    c.b1 = pick_coef(mix, 28);
    c.b2 = pick_coef(mix, 28);
    c.a1 = pick_coef(mix, 29);
    c.a2 = pick_coef(mix, 28);
    return c;
  endfunction

  function automatic sample_t random_sample();
    case ($urandom_range(9))
      0: return $urandom_range(1) ? SMAX : SMIN;
      1: return sample_t'(int'($urandom_range(0, 512)) - 256);
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 50) $display("ERROR at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic write_reg(input logic [bqf_pkg::CFG_ADDR_W-1:0] addr, input coef_word_t data);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= addr;
    cfg_wdata_i <= data;
    case (addr)
      bqf_pkg::REG_B0: coef_shadow.b0 = data;
      bqf_pkg::REG_B1: coef_shadow.b1 = data;
      bqf_pkg::REG_B2: coef_shadow.b2 = data;
      bqf_pkg::REG_A1: coef_shadow.a1 = data;
      bqf_pkg::REG_A2: coef_shadow.a2 = data;
      default: ; // unmapped index: no effect
    endcase
    @(negedge clk_i);
  endtask

  task automatic load_coefs(input bqf_pkg::coef_t c, input bit stray);
    write_reg(bqf_pkg::REG_B0, c.b0);
    write_reg(bqf_pkg::REG_B1, c.b1);
    write_reg(bqf_pkg::REG_B2, c.b2);
    write_reg(bqf_pkg::REG_A1, c.a1);
    write_reg(bqf_pkg::REG_A2, c.a2);
    if (stray) write_reg(bqf_pkg::REG_A2 + 3'($urandom_range(1, 3)), coef_word_t'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic push_sample(input sample_t x, input logic clr, input logic use_fixed,
                             input filter_result_t fixed_res);
    filter_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_in_i <= x;
    clear_history_i <= clr;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = run_filter(x, clr);
    if (use_fixed) predicted = fixed_res;
    pending_results.push_back(predicted);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  always @(negedge clk_i) out_ready_i <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk_i) begin : check_results
    filter_result_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result %0d", sample_out_o));
      end else begin
        exp_res = pending_results.pop_front();
        if (sample_out_o !== exp_res.sample)
          report_mismatch($sformatf("sample_out %0d, expected %0d", sample_out_o,
                                    $signed(exp_res.sample)));
        if (clipped_o !== exp_res.clipped)
          report_mismatch($sformatf("clipped %b, expected %b", clipped_o, exp_res.clipped));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : main_seq
    filter_result_t fixed_res;
    logic [1:0] current_set;
    coef_mix_e mix;
    int mode;
    int seg;
    coef_shadow = DIRECTED_SETS[0];
    tap1_state = '0;
    tap2_state = '0;
    send_idle_pct = 8;
    recv_stall_pct = 61;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    current_set = 2'd0;
    for (int i = 0; i < N_DIRECTED; i++) begin
      if (DIRECTED_ROWS[i].coef_set != current_set) begin
        wait_drained();
        current_set = DIRECTED_ROWS[i].coef_set;
        load_coefs(DIRECTED_SETS[current_set], 1'b0);
      end
      fixed_res.sample = DIRECTED_ROWS[i].y;
      fixed_res.clipped = DIRECTED_ROWS[i].clip;
      push_sample(DIRECTED_ROWS[i].x, DIRECTED_ROWS[i].clr, DIRECTED_ROWS[i].fixed, fixed_res);
    end

    for (mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_idle_pct = 8;
          recv_stall_pct = 61;
        end
        1: begin
          send_idle_pct = 61;
          recv_stall_pct = 8;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      for (seg = 0; seg < 6; seg++) begin
        mix = (seg == 0) ? COEF_EXTREME : (seg == 5) ? COEF_WILD : COEF_MODERATE;
        wait_drained();
        load_coefs(random_coefs(mix), seg == 2);
        repeat (ITEMS_PER_SEG)
          push_sample(random_sample(), $urandom_range(15) == 0, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
